/* hw/rtl/mdf_pkg.sv */
// Shared types, constants and hash step for the message duplicate filter.
package mdf_pkg;

   localparam int          CACHE_ENTRIES_DEFAULT = 32;
   localparam int          QUEUE_DEPTH           = 2;
   localparam int          CSR_ADDR_W            = 3;
   localparam int          CSR_DATA_W            = 32;

   localparam logic [31:0] FNV_BASIS             = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME             = 32'd16777619;
   localparam logic [10:0] MS_PER_SECOND         = 11'd1000;
   localparam logic [7:0]  TOLERANCE_RESET       = 8'd5;
   localparam logic [15:0] HASHED_PAYLOAD_MAX    = 16'd16;
   localparam logic [4:0]  HEADER_LAST           = 5'd14;
   localparam logic [4:0]  SENDER_BYTES          = 5'd8;

   // register index, taken from paddr[2]
   localparam logic        CSR_TOLERANCE         = 1'b0;

   typedef struct packed {
      logic [63:0] sender_id;
      logic [63:0] timestamp_ms;
      logic [7:0]  msg_type;
      logic [15:0] payload_length;
      logic [63:0] payload_head_lo;
      logic [63:0] payload_head_hi;
   } mdf_req_type;

   typedef struct packed {
      logic        is_duplicate;
      logic [31:0] message_hash;
   } mdf_rsp_type;

   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] seconds;
   } mdf_entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_HASH,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SEARCH,
      BACK_REPORT
   } back_state_type;

   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      logic [63:0] p;
      x = h ^ {24'd0, b};
      p = x * FNV_PRIME;
      return p[31:0];
   endfunction

endpackage

/* hw/rtl/message_duplicate_filter.sv */
// Message duplicate filter top level: register port, front, queues and cache back.
//
// Requests enter on req_push/req_full/req_data, results leave on rsp_empty/rsp_pop/rsp_data,
// one result per request and in request order. The tolerance register sits at byte
// address 0 of the csr port; write it only while no request is in flight.
// The front takes a request when idle and folds 15 + min(payload_length,16) bytes into
// the FNV-1a hash, one byte per cycle, then hands the result on to the middle queue; the
// timestamp division by 1000 runs eight quotient bits per cycle beside the sender bytes.
// The front takes no new request until it has handed the last one on.
// The back scans the filled cache entries one per cycle through a registered memory
// read, skips the scan on an empty cache and stops early on a hit. Front and back
// overlap through a two-entry queue; throughput is set by the slower of the two.
// Results wait in a two-entry queue; when it fills the back stops, then the middle
// queue fills and req_full stays high. Reset empties all queues and the cache and sets
// the tolerance to 5 seconds; no clearing pass is needed.
module message_duplicate_filter
   import mdf_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  mdf_req_type           req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output mdf_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]       tol_ff, tol_in;
   logic             csr_write;
   logic             mid_push, mid_full, mid_pop, mid_empty;
   mdf_entry_type    mid_in_data, mid_out_data;
   logic             out_push, out_full;
   mdf_rsp_type      out_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_TOLERANCE);
   assign tol_in     = csr_write ? csr_pwdata[7:0] : tol_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_TOLERANCE) ? {24'd0, tol_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOLERANCE_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   mdf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .mid_push (mid_push),
      .mid_data (mid_in_data),
      .mid_full (mid_full)
   );

   mdf_queue #(
      .item_type (mdf_entry_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_data),
      .empty     (mid_empty)
   );

   mdf_back #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tol_ff),
      .mid_empty (mid_empty),
      .mid_data  (mid_out_data),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   mdf_queue #(
      .item_type (mdf_rsp_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

/* hw/rtl/mdf_queue.sv */
// Small register queue used between the front and back and on the result side.
module mdf_queue
   import mdf_pkg::*;
#(
   parameter type item_type = mdf_entry_type,
   parameter int  DEPTH     = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/mdf_front.sv */
// Front part: accept a request, divide the timestamp by 1000 and fold the FNV-1a hash.
module mdf_front
   import mdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  mdf_req_type   req_data,
   output logic          req_full,
   output logic          mid_push,
   output mdf_entry_type mid_data,
   input  logic          mid_full
);

   front_state_type      state_ff, state_in;
   mdf_req_type          req_ff, req_in;
   logic [4:0]           idx_ff, idx_in;
   logic [4:0]           last_ff, last_in;
   logic [31:0]          hash_ff, hash_in;
   logic [31:0]          quo_ff, quo_in;
   logic [9:0]           rem_ff, rem_in;
   logic [63:0]          dvd_ff, dvd_in;
   logic [31:0][7:0]     stream_w;
   logic [9:0]           div_rem;
   logic [7:0]           div_quo;
   logic [4:0]           head_count;

   assign stream_w = {8'h00, req_ff.payload_head_hi, req_ff.payload_head_lo,
                      req_ff.payload_length, req_ff.msg_type, quo_ff, req_ff.sender_id};

   assign head_count = (req_data.payload_length > HASHED_PAYLOAD_MAX) ?
                       HASHED_PAYLOAD_MAX[4:0] : req_data.payload_length[4:0];

   // eight restoring steps of the long division per cycle
   always_comb begin
      logic [10:0] t;
      div_rem = rem_ff;
      div_quo = '0;
      for (int k = 0; k < 8; k++) begin
         t = {div_rem, dvd_ff[63-k]};
         if (t >= MS_PER_SECOND) begin
            t          = t - MS_PER_SECOND;
            div_quo[7-k] = 1'b1;
         end
         div_rem = t[9:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      hash_in  = hash_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      req_full = 1'b1;
      mid_push = 1'b0;
      mid_data = '{hash: hash_ff, seconds: quo_ff};
      case (state_ff)
         FRONT_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               req_in   = req_data;
               idx_in   = '0;
               last_in  = HEADER_LAST + head_count;
               hash_in  = FNV_BASIS;
               quo_in   = '0;
               rem_in   = '0;
               dvd_in   = req_data.timestamp_ms;
               state_in = FRONT_HASH;
            end
         end
         FRONT_HASH: begin
            hash_in = fnv_step(hash_ff, stream_w[idx_ff]);
            if (idx_ff < SENDER_BYTES) begin
               quo_in = {quo_ff[23:0], div_quo};
               rem_in = div_rem;
               dvd_in = {dvd_ff[55:0], 8'h00};
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == last_ff) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            mid_push = 1'b1;
            if (!mid_full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      hash_ff <= hash_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
   end

endmodule

/* hw/rtl/mdf_back.sv */
// Back part: scan the cache for a matching hash within the tolerance, report, and record new entries.
module mdf_back
   import mdf_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    tolerance,
   input  logic          mid_empty,
   input  mdf_entry_type mid_data,
   output logic          mid_pop,
   input  logic          out_full,
   output logic          out_push,
   output mdf_rsp_type   out_data
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

   mdf_entry_type        cache_ff [CACHE_ENTRIES];
   mdf_entry_type        rdata_ff;
   mdf_entry_type        item_ff, item_in;
   back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 iss_ff, iss_in;
   logic                 cmp_ff, cmp_in;
   logic                 cmp_last_ff, cmp_last_in;
   logic                 dup_ff, dup_in;
   logic                 issue_last;
   logic                 hit;
   logic                 wr_en;
   logic [31:0]          diff;
   logic [31:0]          tol_w;

   assign issue_last = (CNT_W'(addr_ff) == fill_ff - CNT_W'(1));
   assign tol_w      = {24'd0, tolerance};
   assign diff       = item_ff.seconds - rdata_ff.seconds;
   assign hit        = (rdata_ff.hash == item_ff.hash) &&
                       ((diff <= tol_w) || ((32'd0 - diff) <= tol_w));
   assign wr_en      = (state_ff == BACK_REPORT) && !dup_ff;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      addr_in     = addr_ff;
      ptr_in      = ptr_ff;
      fill_in     = fill_ff;
      iss_in      = 1'b0;
      cmp_in      = 1'b0;
      cmp_last_in = 1'b0;
      dup_in      = dup_ff;
      mid_pop     = 1'b0;
      out_push    = 1'b0;
      out_data    = '{is_duplicate: dup_ff, message_hash: item_ff.hash};
      case (state_ff)
         BACK_IDLE: begin
            if (!mid_empty && !out_full) begin
               mid_pop  = 1'b1;
               item_in  = mid_data;
               addr_in  = '0;
               dup_in   = 1'b0;
               iss_in   = (fill_ff != '0);
               state_in = (fill_ff == '0) ? BACK_REPORT : BACK_SEARCH;
            end
         end
         BACK_SEARCH: begin
            if (iss_ff) begin
               cmp_in      = 1'b1;
               cmp_last_in = issue_last;
               iss_in      = !issue_last;
               if (!issue_last) begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (cmp_ff && hit) begin
               dup_in   = 1'b1;
               iss_in   = 1'b0;
               cmp_in   = 1'b0;
               state_in = BACK_REPORT;
            end else if (cmp_ff && cmp_last_ff) begin
               state_in = BACK_REPORT;
            end
         end
         BACK_REPORT: begin
            out_push = 1'b1;
            if (!dup_ff) begin
               ptr_in = (ptr_ff == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
               if (fill_ff != CNT_W'(CACHE_ENTRIES)) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
            state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_IDLE;
         ptr_ff      <= '0;
         fill_ff     <= '0;
         iss_ff      <= 1'b0;
         cmp_ff      <= 1'b0;
         cmp_last_ff <= 1'b0;
         dup_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         fill_ff     <= fill_in;
         iss_ff      <= iss_in;
         cmp_ff      <= cmp_in;
         cmp_last_ff <= cmp_last_in;
         dup_ff      <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cache_ff[ptr_ff] <= item_ff;
      end
      rdata_ff <= cache_ff[addr_ff];
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CACHE_ENTRIES))
      else $error("cache fill count beyond cache size");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff != CNT_W'(CACHE_ENTRIES)) |-> (CNT_W'(ptr_ff) == fill_ff))
      else $error("replace pointer out of step with fill count");

   assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result written into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_SEARCH) |-> (fill_ff != '0))
      else $error("search started on an empty cache");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (fill_ff != '0) && $past(!dup_ff))
      else $error("cache written for a duplicate");
`endif

endmodule

/* test/tb_message_duplicate_filter.sv */
// Testbench for the message duplicate filter: hash, cache search and tolerance register.
`timescale 1ns / 100ps

module tb_message_duplicate_filter
   import mdf_pkg::*;
();

   localparam int CACHE_SLOTS = CACHE_ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS = 125;
   localparam int CALM_ITEMS = 60;
   localparam int HISTORY_DEPTH = 64;
   localparam logic [CSR_ADDR_W-1:0] TOLERANCE_ADDR = {CSR_TOLERANCE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = {~CSR_TOLERANCE, 2'b00};

   class filter_scoreboard;
      bit [7:0]    tolerance;
      bit          slot_valid[CACHE_SLOTS];
      bit [31:0]   slot_hash[CACHE_SLOTS];
      bit [31:0]   slot_secs[CACHE_SLOTS];
      int          replace_slot;
      mdf_rsp_type verdict_q[$];
      int          errors;

      function new();
         tolerance = TOLERANCE_RESET;
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_hash[i] = '0;
            slot_secs[i] = '0;
         end
         replace_slot = 0;
         errors = 0;
      endfunction

      static function bit [31:0] fold_octet(bit [31:0] h, bit [7:0] b);
         bit [31:0] x;
         x = h ^ {24'd0, b};
         return x * FNV_PRIME;
      endfunction

      static function bit [31:0] seconds_of(bit [63:0] ms);
         bit [63:0] q;
         q = ms / 64'(MS_PER_SECOND);
         return q[31:0];
      endfunction

      static function bit [31:0] summary_hash(mdf_req_type r);
         bit [31:0]  h;
         bit [31:0]  secs;
         bit [127:0] body;
         int         n;
         h = FNV_BASIS;
         secs = seconds_of(r.timestamp_ms);
         body = {r.payload_head_hi, r.payload_head_lo};
         n = (r.payload_length < HASHED_PAYLOAD_MAX) ? int'(r.payload_length)
                                                     : int'(HASHED_PAYLOAD_MAX);
         for (int i = 0; i < 8; i++) h = fold_octet(h, r.sender_id[8*i +: 8]);
         for (int i = 0; i < 4; i++) h = fold_octet(h, secs[8*i +: 8]);
         h = fold_octet(h, r.msg_type);
         h = fold_octet(h, r.payload_length[7:0]);
         h = fold_octet(h, r.payload_length[15:8]);
         for (int i = 0; i < n; i++) h = fold_octet(h, body[8*i +: 8]);
         return h;
      endfunction

      function void note_request(mdf_req_type r);
         mdf_rsp_type v;
         bit [31:0]   secs;
         bit [31:0]   d;
         bit [31:0]   back;
         v.message_hash = summary_hash(r);
         v.is_duplicate = 1'b0;
         secs = seconds_of(r.timestamp_ms);
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (slot_valid[i] && slot_hash[i] == v.message_hash) begin
               d = secs - slot_secs[i];
               back = 32'd0 - d;
               if (d <= tolerance || back <= tolerance) v.is_duplicate = 1'b1;
            end
         end
         if (!v.is_duplicate) begin
            slot_valid[replace_slot] = 1'b1;
            slot_hash[replace_slot] = v.message_hash;
            slot_secs[replace_slot] = secs;
            replace_slot = (replace_slot + 1) % CACHE_SLOTS;
         end
         verdict_q.push_back(v);
      endfunction

      function void check_result(mdf_rsp_type got);
         mdf_rsp_type e;
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected result dup=%0b hash=%08h", $time,
                     got.is_duplicate, got.message_hash);
            errors++;
            return;
         end
         e = verdict_q.pop_front();
         if (got.is_duplicate !== e.is_duplicate) begin
            $display("%0t: is_duplicate expected %0b got %0b (hash %08h)", $time,
                     e.is_duplicate, got.is_duplicate, e.message_hash);
            errors++;
         end
         if (got.message_hash !== e.message_hash) begin
            $display("%0t: message_hash expected %08h got %08h", $time,
                     e.message_hash, got.message_hash);
            errors++;
         end
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   typedef struct {
      bit [23:0] first;
      bit [23:0] second;
   } twin_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   mdf_req_type           req_data = '0;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   mdf_rsp_type           rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   filter_scoreboard sb;
   mdf_req_type      history[$];
   twin_type         twins[$];
   bit [63:0]        now_ms;
   bit [63:0]        twin_sender;
   bit [7:0]         twin_kind;
   bit [31:0]        twin_base;
   bit [63:0]        twin_tail;
   bit               calm = 1'b0;
   bit               long_hold_req = 1'b0;
   int               cycle_count = 0;

   message_duplicate_filter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_message_duplicate_filter: done, errors");
      $finish;
   end

   // Collect each result; stall in random bursts or for one long hold-off.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_data);
         if (long_hold_req) begin
            stall = LONG_HOLD;
            long_hold_req = 1'b0;
         end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 14);
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic mdf_req_type fresh_message();
      mdf_req_type r;
      r.sender_id = {$urandom, $urandom};
      now_ms += 64'($urandom_range(0, 3000));
      r.timestamp_ms = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : now_ms;
      r.msg_type = 8'($urandom);
      r.payload_length = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 20))
                                                    : 16'($urandom);
      r.payload_head_lo = {$urandom, $urandom};
      r.payload_head_hi = {$urandom, $urandom};
      return r;
   endfunction

   // Change only the payload bytes that lie beyond the hashed length.
   function automatic mdf_req_type scramble_tail(mdf_req_type r);
      bit [127:0] body;
      bit [127:0] keep;
      int         n;
      n = (r.payload_length < HASHED_PAYLOAD_MAX) ? int'(r.payload_length)
                                                  : int'(HASHED_PAYLOAD_MAX);
      keep = (128'd1 << (8 * n)) - 128'd1;
      body = {r.payload_head_hi, r.payload_head_lo};
      body = (body & keep) | ({$urandom, $urandom, $urandom, $urandom} & ~keep);
      {r.payload_head_hi, r.payload_head_lo} = body;
      return r;
   endfunction

   function automatic mdf_req_type twin_message(bit [23:0] code);
      mdf_req_type r;
      bit [31:0]   secs;
      secs = twin_base + 32'(code[23:16]);
      r.sender_id = twin_sender;
      r.timestamp_ms = {32'd0, secs} * 64'd1000 + 64'($urandom_range(0, 999));
      r.msg_type = twin_kind;
      r.payload_length = 16'd2;
      r.payload_head_lo = {twin_tail[63:16], code[15:0]};
      r.payload_head_hi = ~twin_tail;
      return r;
   endfunction

   // Hunt for hash collisions among twin summaries that differ only in their seconds and first two payload bytes.
   task automatic find_twins();
      bit [23:0] seen[bit [31:0]];
      bit [23:0] code;
      bit [31:0] h;
      twin_type  t;
      twin_sender = {$urandom, $urandom};
      twin_kind = 8'($urandom);
      twin_base = $urandom;
      twin_tail = {$urandom, $urandom};
      for (int i = 0; i < 131072 && twins.size() < 6; i++) begin
         code = 24'($urandom);
         h = filter_scoreboard::summary_hash(twin_message(code));
         if (seen.exists(h)) begin
            if (seen[h] != code) begin
               t.first = seen[h];
               t.second = code;
               twins.push_back(t);
            end
         end else begin
            seen[h] = code;
         end
      end
   endtask

   function automatic mdf_req_type next_message();
      mdf_req_type r;
      int          sel;
      int          depth;
      twin_type    t;
      sel = $urandom_range(0, 99);
      if (history.size() == 0 || sel < 45) return fresh_message();
      depth = (history.size() < 8) ? history.size() : 8;
      r = history[history.size() - 1 - $urandom_range(0, depth - 1)];
      if (sel < 70) begin
         r.timestamp_ms = r.timestamp_ms - r.timestamp_ms % 64'd1000
                          + 64'($urandom_range(0, 999));
      end else if (sel < 80) begin
         r = scramble_tail(r);
      end else if (sel < 90 && twins.size() > 0) begin
         t = twins[$urandom_range(0, twins.size() - 1)];
         r = twin_message($urandom_range(0, 1) ? t.first : t.second);
      end else begin
         r = history[$urandom_range(0, history.size() - 1)];
      end
      return r;
   endfunction

   task automatic send_request(input mdf_req_type r);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(r);
      history.push_back(r);
      if (history.size() > HISTORY_DEPTH) void'(history.pop_front());
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[2] == CSR_TOLERANCE) sb.tolerance = data[7:0];
      @(posedge clock);
   endtask

   task automatic csr_check_tolerance();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= TOLERANCE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[7:0] !== sb.tolerance) begin
         $display("%0t: tolerance read expected %0d got %0d", $time, sb.tolerance,
                  csr_prdata[7:0]);
         sb.errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      mdf_req_type z;
      mdf_req_type m;
      int          lens[7];
      bit [7:0]    phase_tol[4];
      lens = '{1, 7, 8, 9, 15, 16, 17};
      sb = new();
      now_ms = {24'd0, $urandom, 8'd0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      find_twins();

      z = '0;
      send_request(z);
      m = '1;
      send_request(m);
      send_request(m);
      m = z;
      m.timestamp_ms = 64'd999;
      send_request(m);
      m.timestamp_ms = 64'd1000;
      send_request(m);
      foreach (lens[i]) begin
         m = fresh_message();
         m.payload_length = 16'(lens[i]);
         send_request(m);
      end
      m = fresh_message();
      m.payload_length = 16'd5;
      send_request(m);
      send_request(scramble_tail(m));
      m = z;
      m.timestamp_ms = 64'd4294967296 * 64'd1000;
      send_request(m);
      m.timestamp_ms = 64'd2147483648 * 64'd1000;
      send_request(m);
      foreach (twins[i]) begin
         if (i < 2) begin
            send_request(twin_message(twins[i].first));
            send_request(twin_message(twins[i].second));
         end
      end
      wait_idle();
      csr_check_tolerance();

      phase_tol = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd0};
      foreach (phase_tol[p]) begin
         wait_idle();
         csr_write(SPARE_ADDR, $urandom);
         csr_write(TOLERANCE_ADDR, {24'($urandom_range(0, 16777215)), phase_tol[p]});
         csr_check_tolerance();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 10) long_hold_req = 1'b1;
            if (p == 3 && i == PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (twins.size() > 0 && i < 2 * twins.size() && i % 2 == 0)
               send_request(twin_message(twins[i / 2].first));
            else if (twins.size() > 0 && i < 2 * twins.size())
               send_request(twin_message(twins[i / 2].second));
            else
               send_request(next_message());
         end
      end

      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_message_duplicate_filter: done, clean");
      end else begin
         $display("tb_message_duplicate_filter: done, errors");
      end
      $finish;
   end

endmodule
